/* design/bfra_pkg.sv */
// Shared types and constants for the best-fit range allocator.
package bfra_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NOFIT = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_ZERO  = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [31:0] range_start;
		logic [31:0] range_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_start;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic sel;
		logic rem;
		logic split;
		logic ins;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic full;
		logic found;
		logic exact;
	} dp_stat_t;

endpackage

/* design/bfra_dp.sv */
// Datapath of the allocator: the sorted chain of free-range cells and its working registers.
module bfra_dp #(
	parameter int SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfra_pkg::req_t    req,
	input  bfra_pkg::dp_cmd_t cmd,
	output bfra_pkg::dp_stat_t stat,
	output logic [31:0]       grant
);
	import bfra_pkg::*;

	localparam int CW = $clog2(SLOTS + 1);

	logic [31:0]   cell_start_q [SLOTS];
	logic [31:0]   cell_size_q  [SLOTS];
	logic [CW-1:0] count_q;
	logic [SLOTS-1:0] lt_q;
	logic [31:0]   key_q;
	logic [31:0]   new_start_q;
	logic [31:0]   base_q;
	logic [31:0]   have_q;
	logic          found_q;
	logic [31:0]   grant_q;

	logic [SLOTS-1:0] valid;
	logic [SLOTS-1:0] pick;
	logic [31:0]      pick_start;
	logic [31:0]      pick_size;
	logic             pick_any;

	always_comb begin
		pick_start = '0;
		pick_size  = '0;
		pick_any   = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			valid[i] = CW'(i) < count_q;
			if (i == 0) begin
				pick[i] = valid[i] && !lt_q[i];
			end else begin
				pick[i] = valid[i] && !lt_q[i] && lt_q[i-1];
			end
			pick_any   = pick_any | pick[i];
			pick_start = pick_start | (pick[i] ? cell_start_q[i] : 32'd0);
			pick_size  = pick_size | (pick[i] ? cell_size_q[i] : 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.sel) begin
				found_q <= pick_any;
			end
			if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q       <= req.range_size;
			new_start_q <= req.range_start;
			grant_q     <= '0;
		end else if (cmd.split) begin
			key_q       <= have_q - key_q;
			new_start_q <= base_q + key_q;
		end
		if (cmd.cmp) begin
			for (int i = 0; i < SLOTS; i++) begin
				lt_q[i] <= valid[i] && (cell_size_q[i] < key_q);
			end
		end
		if (cmd.sel) begin
			base_q  <= pick_start;
			have_q  <= pick_size;
			grant_q <= pick_any ? pick_start : 32'd0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.rem) begin
				if (i < SLOTS - 1 && !lt_q[i]) begin
					cell_start_q[i] <= cell_start_q[(i + 1) % SLOTS];
					cell_size_q[i]  <= cell_size_q[(i + 1) % SLOTS];
				end
			end else if (cmd.ins) begin
				if (i > 0 && !lt_q[(i + SLOTS - 1) % SLOTS]) begin
					cell_start_q[i] <= cell_start_q[(i + SLOTS - 1) % SLOTS];
					cell_size_q[i]  <= cell_size_q[(i + SLOTS - 1) % SLOTS];
				end else if (!lt_q[i]) begin
					cell_start_q[i] <= new_start_q;
					cell_size_q[i]  <= key_q;
				end
			end
		end
	end

	assign stat.zero  = req.range_size == 32'd0;
	assign stat.full  = count_q == CW'(SLOTS);
	assign stat.found = found_q;
	assign stat.exact = have_q == key_q;
	assign grant      = grant_q;

endmodule

/* design/bfra_ctrl.sv */
// Controller state machine that sequences compare, select, remove and insert steps.
module bfra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_cmd,
	input  bfra_pkg::dp_stat_t stat,
	output bfra_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status
);
	import bfra_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_REM  = 3'd3;
	localparam logic [2:0] ST_INS  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ins_mode_q;
	logic       ins_mode_d;
	logic       done_q;
	logic       done_d;
	logic [1:0] status_q;
	logic [1:0] status_d;

	always_comb begin
		state_d    = state_q;
		ins_mode_d = ins_mode_q;
		done_d     = 1'b0;
		status_d   = status_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (stat.zero) begin
						done_d   = 1'b1;
						status_d = STATUS_ZERO;
					end else begin
						ins_mode_d = req_cmd == CMD_ADD;
						state_d    = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ins_mode_q ? ST_INS : ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				if (!stat.found) begin
					done_d   = 1'b1;
					status_d = STATUS_NOFIT;
					state_d  = ST_IDLE;
				end else begin
					cmd.rem = 1'b1;
					if (stat.exact) begin
						done_d   = 1'b1;
						status_d = STATUS_OK;
						state_d  = ST_IDLE;
					end else begin
						cmd.split  = 1'b1;
						ins_mode_d = 1'b1;
						state_d    = ST_CMP;
					end
				end
			end
			ST_INS: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				if (stat.full) begin
					status_d = STATUS_FULL;
				end else begin
					cmd.ins  = 1'b1;
					status_d = STATUS_OK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ins_mode_q <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= STATUS_OK;
		end else begin
			state_q    <= state_d;
			ins_mode_q <= ins_mode_d;
			done_q     <= done_d;
			status_q   <= status_d;
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign status = status_q;

endmodule

/* design/best_fit_range_allocator.sv */
// Top level of the best-fit range allocator.
// A zero size is rejected without a search. An add runs the compare and insert steps; an
// allocate runs compare, select and remove, and an allocate that splits then runs compare and insert.
// The sorted cell chain is searched by the compare step; a request occupies the block until its
// result, busy falls in the result cycle and a new transfer may start there.
// arst_n clears the controller and the entry count; the table then reads as empty.
module best_fit_range_allocator #(
	parameter int SLOTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bfra_pkg::req_t req,
	output logic           done,
	output bfra_pkg::rsp_t rsp
);
	import bfra_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] grant;
	logic [1:0]  status;

	bfra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_cmd (req.cmd),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.status  (status)
	);

	bfra_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.grant  (grant)
	);

	assign rsp.status        = status;
	assign rsp.granted_start = grant;

endmodule

/* design/bfra_checker.sv */
// Port-level checks for the best-fit range allocator and their bind.
module bfra_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input bfra_pkg::req_t req,
	input logic           done,
	input bfra_pkg::rsp_t rsp
);
	import bfra_pkg::*;

	a_zero_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.range_size == 32'd0) |=> (done && rsp.status == STATUS_ZERO))
		else $error("zero size transfer not rejected in the next cycle");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.range_size != 32'd0) |=> (busy && !done))
		else $error("block not busy after a nonzero transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != STATUS_OK) |-> rsp.granted_start == 32'd0)
		else $error("nonzero grant on a failed request");

endmodule

bind best_fit_range_allocator bfra_checker u_bfra_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

/* bench/bfra_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts allocator results from the observed commands and compares them.
module bfra_scoreboard #(
	parameter int SLOTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  bfra_pkg::req_t req,
	input  logic           done,
	input  bfra_pkg::rsp_t rsp,
	output int             errors,
	output int             pending,
	output int             status_seen [4]
);

	import bfra_pkg::*;

	logic [31:0] free_start [SLOTS];
	logic [31:0] free_size  [SLOTS];
	int          free_cnt;
	rsp_t        grant_q [$];

	function automatic int fit_pos(input logic [31:0] sz);
		int i;
		i = 0;
		while (i < free_cnt && free_size[i] < sz)
			i++;
		return i;
	endfunction

	task automatic take_out(input int pos);
		for (int i = pos; i + 1 < free_cnt; i++) begin
			free_start[i] = free_start[i + 1];
			free_size[i]  = free_size[i + 1];
		end
		free_cnt--;
	endtask

	// New ranges go ahead of any entries of the same size.
	task automatic put_in(input logic [31:0] st, input logic [31:0] sz);
		int pos;
		pos = fit_pos(sz);
		for (int i = free_cnt; i > pos; i--) begin
			free_start[i] = free_start[i - 1];
			free_size[i]  = free_size[i - 1];
		end
		free_start[pos] = st;
		free_size[pos]  = sz;
		free_cnt++;
	endtask

	task automatic model_request(input req_t r, output rsp_t e);
		int          pos;
		logic [31:0] have;
		logic [31:0] base;
		e        = '0;
		e.status = STATUS_OK;
		if (r.range_size == '0) begin
			e.status = STATUS_ZERO;
		end else if (r.cmd == CMD_ADD) begin
			if (free_cnt >= SLOTS)
				e.status = STATUS_FULL;
			else
				put_in(r.range_start, r.range_size);
		end else begin
			pos = fit_pos(r.range_size);
			if (pos >= free_cnt) begin
				e.status = STATUS_NOFIT;
			end else begin
				have            = free_size[pos];
				base            = free_start[pos];
				e.granted_start = base;
				take_out(pos);
				if (have != r.range_size)
					put_in(base + r.range_size, have - r.range_size);
			end
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			free_cnt = 0;
			grant_q.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (grant_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result status %0d start %h with no command outstanding",
							$realtime, rsp.status, rsp.granted_start);
					errors++;
				end else begin
					want = grant_q.pop_front();
					if (rsp.status !== want.status || rsp.granted_start !== want.granted_start) begin
						if (errors < 10)
							$display("%0t: mismatch status exp %0d got %0d, start exp %h got %h",
								$realtime, want.status, rsp.status,
								want.granted_start, rsp.granted_start);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				model_request(req, want);
				grant_q.push_back(want);
				status_seen[want.status]++;
			end
			pending = grant_q.size();
		end
	end

endmodule

/* bench/tb_best_fit_range_allocator.sv */
`timescale 1ns / 1ps
// Testbench top that drives allocator commands in paced phases and reports the verdict.
module tb_best_fit_range_allocator;

	import bfra_pkg::*;

	localparam int SLOTS       = 64;
	localparam int STALL_LIMIT = 2000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	int errors;
	int pending;
	int status_seen [4];
	int idle_pct = 0;
	int sent     = 0;
	int quiet    = 0;

	best_fit_range_allocator #(.SLOTS(SLOTS)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	bfra_scoreboard #(.SLOTS(SLOTS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.errors     (errors),
		.pending    (pending),
		.status_seen(status_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else if (quiet + 1 >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
				$display("best_fit_range_allocator test failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic issue(input logic c, input logic [31:0] st, input logic [31:0] sz);
		req_t r;
		r.cmd         = c;
		r.range_start = st;
		r.range_size  = sz;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return $urandom();
		if (pick < 80)
			return $urandom_range(1, 16);
		return $urandom_range(1, 256);
	endfunction

	function automatic logic [31:0] rand_start();
		if ($urandom_range(0, 9) == 0)
			return 32'hFFFF_FF00 | $urandom_range(0, 255);
		return $urandom();
	endfunction

	task automatic run_phase(input int count, input int add_pct, input int burst);
		logic c;
		for (int i = 0; i < count; i++) begin
			c = (i < burst || $urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_ALLOC;
			issue(c, rand_start(), rand_size());
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);

		issue(CMD_ALLOC, 32'h0000_0000, 32'd5);
		issue(CMD_ALLOC, 32'h0000_1000, 32'd0);
		issue(CMD_ADD,   32'h0000_1000, 32'd0);
		issue(CMD_ADD,   32'h0000_1000, 32'd16);
		issue(CMD_ADD,   32'h0000_2000, 32'd16);
		issue(CMD_ADD,   32'hFFFF_FFF0, 32'h40);
		issue(CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_ADD,   32'h0000_0000, 32'd1);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd16);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd16);
		issue(CMD_ALLOC, 32'h0000_0000, 32'h20);
		issue(CMD_ALLOC, 32'h0000_0000, 32'h20);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd1);
		issue(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd1);
		issue(CMD_ADD,   32'h8000_0000, 32'd100);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd30);
		issue(CMD_ADD,   32'h5555_5555, 32'd70);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd70);
		issue(CMD_ALLOC, 32'h0000_0000, 32'd71);
		issue(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(CMD_ALLOC, 32'hFFFF_FFFF, 32'd70);
		issue(CMD_ADD,   32'hAAAA_AAAA, 32'h8000_0000);
		issue(CMD_ALLOC, 32'h0000_0000, 32'h7FFF_FFFF);
		drain();

		idle_pct = 0;
		run_phase(110, 50, 70);
		idle_pct = 60;
		run_phase(110, 55, 0);
		idle_pct = 0;
		run_phase(110, 25, 0);
		idle_pct = 29;
		run_phase(110, 50, 0);

		repeat (8) @(posedge clk);
		$display("Ran %0d commands over four pacing phases, including a fill to capacity.", sent);
		$display("Results: %0d ok, %0d no fit, %0d table full, %0d zero size.",
			status_seen[STATUS_OK], status_seen[STATUS_NOFIT],
			status_seen[STATUS_FULL], status_seen[STATUS_ZERO]);
		if (errors == 0 && pending == 0)
			$display("best_fit_range_allocator test passed");
		else
			$display("best_fit_range_allocator test failed");
		$finish;
	end

endmodule
